// File: src/wsm_pkg.sv
package wsm_pkg;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_IDX_W  = 8;
    localparam int DIV_STEPS  = 48;

    // input item modes
    localparam logic [1:0] MODE_MAP    = 2'd0;
    localparam logic [1:0] MODE_SEG    = 2'd1;
    localparam logic [1:0] MODE_MEMBER = 2'd2;

    // result status codes
    localparam logic [2:0] ST_MAPPED   = 3'd0;
    localparam logic [2:0] ST_NO_SEG   = 3'd1;
    localparam logic [2:0] ST_BAD_GEO  = 3'd2;
    localparam logic [2:0] ST_NO_COVER = 3'd3;
    localparam logic [2:0] ST_LOADED   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SEGMENTS = 8'd1;

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_WRITE   = 4'd2;
    localparam logic [3:0] OP_PROBE   = 4'd3;
    localparam logic [3:0] OP_COMPARE = 4'd4;
    localparam logic [3:0] OP_GEOM    = 4'd5;
    localparam logic [3:0] OP_DIV     = 4'd6;
    localparam logic [3:0] OP_MREAD   = 4'd7;
    localparam logic [3:0] OP_MMUL    = 4'd8;
    localparam logic [3:0] OP_MCMP    = 4'd9;
    localparam logic [3:0] OP_PMUL_LL = 4'd10;
    localparam logic [3:0] OP_PMUL_LH = 4'd11;
    localparam logic [3:0] OP_PMUL_HL = 4'd12;
    localparam logic [3:0] OP_ACC_LO  = 4'd13;
    localparam logic [3:0] OP_ACC_HI  = 4'd14;
    localparam logic [3:0] OP_FINISH  = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] code;
    } cmd_t;

    typedef struct packed {
        logic search_open;
        logic probe_hit;
        logic geom_bad;
        logic div_last;
        logic member_hit;
        logic member_last;
        logic out_free;
    } stat_t;

endpackage

// File: src/wsm_ram.sv
module wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/wsm_datapath.sv
module wsm_datapath #(
    parameter int SEGMENTS    = 16,
    parameter int MAX_MEMBERS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wsm_pkg::cmd_t                    cmd,
    output wsm_pkg::stat_t                   stat,
    input  logic [wsm_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             cfg_valid,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [wsm_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [2:0]                       m_tuser
);

    localparam int SEG_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int MEM_DEPTH = SEGMENTS * MAX_MEMBERS;
    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W = $clog2(SEGMENTS + 1);
    localparam int SUM_W = 49 + ((MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 0);
    localparam int SEG_W = 132;

    logic                          out_free;

    logic [1:0]                    mode_reg;
    logic [wsm_pkg::IN_DATA_W-1:0] in_reg;
    logic [31:0]                   chunk_reg;
    logic [4:0]                    active_reg;

    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  mid;
    logic [8:0]        n_clamp;

    logic [SEG_AW-1:0] seg_reg;
    logic [31:0]       stripe_reg;
    logic [3:0]        count_reg;
    logic [47:0]       rel_reg;

    logic [31:0]       rem_reg;
    logic [47:0]       quo_reg;
    logic [5:0]        div_cnt_reg;
    logic [32:0]       div_t;
    logic              div_ge;

    logic [3:0]        idx_reg;
    logic [SUM_W-1:0]  lower_reg;
    logic [SUM_W-1:0]  upper;
    logic [7:0]        disk_reg;
    logic [47:0]       extent_reg;

    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod_reg;
    logic [63:0]       acc_reg;

    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [7:0]        out_disk_reg;
    logic [3:0]        out_seg_reg;
    logic [63:0]       out_off_reg;
    logic [47:0]       out_ext_reg;

    logic [47:0]       x;
    logic [3:0]        sslot;
    logic [2:0]        mslot;
    logic              seg_slot_ok;
    logic              mem_slot_ok;

    logic              seg_we;
    logic              seg_re;
    logic [SEG_AW-1:0] seg_addr;
    logic [SEG_W-1:0]  seg_wdata;
    logic [SEG_W-1:0]  seg_rdata;
    logic [47:0]       rd_begin;
    logic [47:0]       rd_end;
    logic [31:0]       rd_stripe;
    logic [3:0]        rd_count;

    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [23:0]       mem_wdata;
    logic [23:0]       mem_rdata;

    logic [2:0]        fin_code;
    logic              fin_mapped;

    assign x     = in_reg[47:0];
    assign sslot = in_reg[51:48];
    assign mslot = in_reg[54:52];

    assign seg_slot_ok = (9'(sslot) < 9'(SEGMENTS));
    assign mem_slot_ok = seg_slot_ok && (5'(mslot) < 5'(MAX_MEMBERS));

    assign n_clamp = (9'(active_reg) > 9'(SEGMENTS)) ? 9'(SEGMENTS) : 9'(active_reg);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // segment table: {count, stripe, end, begin}
    assign seg_we    = (cmd.op == wsm_pkg::OP_WRITE) && (mode_reg == wsm_pkg::MODE_SEG)
                       && seg_slot_ok;
    assign seg_re    = (cmd.op == wsm_pkg::OP_PROBE);
    assign seg_addr  = (cmd.op == wsm_pkg::OP_WRITE) ? SEG_AW'(sslot) : SEG_AW'(mid);
    assign seg_wdata = {in_reg[186:183], in_reg[182:151], in_reg[150:103], in_reg[102:55]};
    assign rd_begin  = seg_rdata[47:0];
    assign rd_end    = seg_rdata[95:48];
    assign rd_stripe = seg_rdata[127:96];
    assign rd_count  = seg_rdata[131:128];

    // member table: {disk, weight}
    assign mem_we    = (cmd.op == wsm_pkg::OP_WRITE) && (mode_reg == wsm_pkg::MODE_MEMBER)
                       && mem_slot_ok;
    assign mem_re    = (cmd.op == wsm_pkg::OP_MREAD);
    assign mem_addr  = (cmd.op == wsm_pkg::OP_WRITE)
                       ? MEM_AW'(sslot) * MEM_AW'(MAX_MEMBERS) + MEM_AW'(mslot)
                       : MEM_AW'(seg_reg) * MEM_AW'(MAX_MEMBERS) + MEM_AW'(idx_reg);
    assign mem_wdata = {in_reg[210:203], in_reg[202:187]};

    wsm_ram #(
        .WIDTH (SEG_W),
        .DEPTH (SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .re    (seg_re),
        .addr  (seg_addr),
        .wdata (seg_wdata),
        .rdata (seg_rdata)
    );

    wsm_ram #(
        .WIDTH (24),
        .DEPTH (MEM_DEPTH)
    ) u_mem_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // restoring divide, one quotient bit per cycle
    assign div_t  = {rem_reg, quo_reg[47]};
    assign div_ge = (div_t >= {1'b0, stripe_reg});

    assign upper = lower_reg + SUM_W'(prod_reg[47:0]);

    always_comb
    begin
        mul_a = chunk_reg;
        mul_b = 32'(mem_rdata[15:0]);
        case (cmd.op)
            wsm_pkg::OP_PMUL_LL:
            begin
                mul_a = quo_reg[31:0];
                mul_b = extent_reg[31:0];
            end
            wsm_pkg::OP_PMUL_LH:
            begin
                mul_a = quo_reg[31:0];
                mul_b = 32'(extent_reg[47:32]);
            end
            wsm_pkg::OP_PMUL_HL:
            begin
                mul_a = 32'(quo_reg[47:32]);
                mul_b = extent_reg[31:0];
            end
            default:
            begin
                mul_a = chunk_reg;
                mul_b = 32'(mem_rdata[15:0]);
            end
        endcase
    end

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (x < rd_begin)
        begin
            hi_next = mid_reg;
        end
        else if (x >= rd_end)
        begin
            lo_next = mid_reg + CNT_W'(1);
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    assign stat.search_open = (lo_reg < hi_reg);
    assign stat.probe_hit   = (x >= rd_begin) && (x < rd_end);
    assign stat.geom_bad    = (stripe_reg == 32'd0) || (count_reg == 4'd0)
                              || (5'(count_reg) > 5'(MAX_MEMBERS));
    assign stat.div_last    = (div_cnt_reg == 6'(wsm_pkg::DIV_STEPS - 1));
    assign stat.member_hit  = (SUM_W'(rem_reg) >= lower_reg) && (SUM_W'(rem_reg) < upper);
    assign stat.member_last = ((5'(idx_reg) + 5'd1) == 5'(count_reg));
    assign stat.out_free    = out_free;

    assign fin_code   = cmd.code;
    assign fin_mapped = (fin_code == wsm_pkg::ST_MAPPED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= 32'd65536;
            active_reg <= 5'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == wsm_pkg::CFG_CHUNK_BYTES)
            begin
                chunk_reg <= cfg_data;
            end
            else if (cfg_index == wsm_pkg::CFG_ACTIVE_SEGMENTS)
            begin
                active_reg <= cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == wsm_pkg::OP_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            wsm_pkg::OP_LATCH:
            begin
                in_reg    <= s_tdata;
                mode_reg  <= s_tuser;
                lo_reg    <= '0;
                hi_reg    <= CNT_W'(n_clamp);
                seg_reg   <= '0;
                idx_reg   <= 4'd0;
                lower_reg <= '0;
            end
            wsm_pkg::OP_PROBE:
            begin
                mid_reg <= mid;
            end
            wsm_pkg::OP_COMPARE:
            begin
                lo_reg     <= lo_next;
                hi_reg     <= hi_next;
                seg_reg    <= SEG_AW'(mid_reg);
                stripe_reg <= rd_stripe;
                count_reg  <= rd_count;
                rel_reg    <= x - rd_begin;
            end
            wsm_pkg::OP_GEOM:
            begin
                rem_reg     <= 32'd0;
                quo_reg     <= rel_reg;
                div_cnt_reg <= 6'd0;
            end
            wsm_pkg::OP_DIV:
            begin
                rem_reg     <= div_ge ? 32'(div_t - {1'b0, stripe_reg}) : div_t[31:0];
                quo_reg     <= {quo_reg[46:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            wsm_pkg::OP_MMUL:
            begin
                prod_reg <= mul_a * mul_b;
                disk_reg <= mem_rdata[23:16];
            end
            wsm_pkg::OP_MCMP:
            begin
                if (stat.member_hit)
                begin
                    extent_reg <= prod_reg[47:0];
                    acc_reg    <= 64'(rem_reg) - 64'(lower_reg);
                end
                else
                begin
                    lower_reg <= upper;
                    idx_reg   <= idx_reg + 4'd1;
                end
            end
            wsm_pkg::OP_PMUL_LL,
            wsm_pkg::OP_PMUL_LH,
            wsm_pkg::OP_PMUL_HL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            wsm_pkg::OP_ACC_LO:
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            wsm_pkg::OP_ACC_HI:
            begin
                acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            end
            wsm_pkg::OP_FINISH:
            begin
                out_status_reg <= fin_code;
                out_disk_reg   <= fin_mapped ? disk_reg : 8'd0;
                out_seg_reg    <= (fin_mapped || fin_code == wsm_pkg::ST_BAD_GEO
                                   || fin_code == wsm_pkg::ST_NO_COVER) ? 4'(seg_reg) : 4'd0;
                out_off_reg    <= fin_mapped ? acc_reg : 64'd0;
                out_ext_reg    <= fin_mapped ? extent_reg : 48'd0;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_ext_reg, out_off_reg, out_seg_reg, out_disk_reg};

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wsm_pkg::OP_FINISH) |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wsm_pkg::OP_DIV) |-> (rem_reg < stripe_reg))
        else $error("divider remainder out of range");

    a_within_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wsm_pkg::OP_MCMP) |-> (SUM_W'(rem_reg) >= lower_reg))
        else $error("member scan passed the offset");

    a_mapped_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == wsm_pkg::ST_MAPPED) |-> (out_ext_reg != 48'd0))
        else $error("mapped result with empty extent");

endmodule

// File: src/wsm_ctrl.sv
module wsm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic [1:0]     s_tuser,
    output logic           s_tready,
    input  wsm_pkg::stat_t stat,
    output wsm_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRITE  = 4'd1;
    localparam logic [3:0] S_SEARCH = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_GEOM   = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_MREAD  = 4'd6;
    localparam logic [3:0] S_MMUL   = 4'd7;
    localparam logic [3:0] S_MCMP   = 4'd8;
    localparam logic [3:0] S_LL     = 4'd9;
    localparam logic [3:0] S_ACCL   = 4'd10;
    localparam logic [3:0] S_LH     = 4'd11;
    localparam logic [3:0] S_ACCH1  = 4'd12;
    localparam logic [3:0] S_HL     = 4'd13;
    localparam logic [3:0] S_ACCH2  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [2:0] code_reg, code_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = wsm_pkg::OP_NONE;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = wsm_pkg::OP_LATCH;
                    if (s_tuser == wsm_pkg::MODE_MAP)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (s_tuser == wsm_pkg::MODE_SEG || s_tuser == wsm_pkg::MODE_MEMBER)
                    begin
                        state_next = S_WRITE;
                        code_next  = wsm_pkg::ST_LOADED;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        code_next  = wsm_pkg::ST_LOADED;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.op     = wsm_pkg::OP_WRITE;
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (stat.search_open)
                begin
                    cmd.op     = wsm_pkg::OP_PROBE;
                    state_next = S_CMP;
                end
                else
                begin
                    code_next  = wsm_pkg::ST_NO_SEG;
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                cmd.op     = wsm_pkg::OP_COMPARE;
                state_next = stat.probe_hit ? S_GEOM : S_SEARCH;
            end
            S_GEOM:
            begin
                cmd.op = wsm_pkg::OP_GEOM;
                if (stat.geom_bad)
                begin
                    code_next  = wsm_pkg::ST_BAD_GEO;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = wsm_pkg::OP_DIV;
                if (stat.div_last)
                begin
                    state_next = S_MREAD;
                end
            end
            S_MREAD:
            begin
                cmd.op     = wsm_pkg::OP_MREAD;
                state_next = S_MMUL;
            end
            S_MMUL:
            begin
                cmd.op     = wsm_pkg::OP_MMUL;
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                cmd.op = wsm_pkg::OP_MCMP;
                if (stat.member_hit)
                begin
                    state_next = S_LL;
                end
                else if (stat.member_last)
                begin
                    code_next  = wsm_pkg::ST_NO_COVER;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MREAD;
                end
            end
            S_LL:
            begin
                cmd.op     = wsm_pkg::OP_PMUL_LL;
                state_next = S_ACCL;
            end
            S_ACCL:
            begin
                cmd.op     = wsm_pkg::OP_ACC_LO;
                state_next = S_LH;
            end
            S_LH:
            begin
                cmd.op     = wsm_pkg::OP_PMUL_LH;
                state_next = S_ACCH1;
            end
            S_ACCH1:
            begin
                cmd.op     = wsm_pkg::OP_ACC_HI;
                state_next = S_HL;
            end
            S_HL:
            begin
                cmd.op     = wsm_pkg::OP_PMUL_HL;
                state_next = S_ACCH2;
            end
            S_ACCH2:
            begin
                cmd.op     = wsm_pkg::OP_ACC_HI;
                code_next  = wsm_pkg::ST_MAPPED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = wsm_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= wsm_pkg::ST_LOADED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !stat.out_free) |=> (state_reg == S_DONE))
        else $error("result state left while output full");

endmodule

// File: src/weighted_stripe_mapper_top.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata map/setup fields
// m_      | out | m_tvalid/m_tready  | m_tuser status, m_tdata mapping result
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// setup items write their table entry, unused-mode items write nothing; a mapped item runs search probes
// (up to log2(SEGMENTS)+1 probes), 48 divide steps of the 1-bit-per-cycle divider, the member scan
// and the offset multiply-accumulate; error results end early
// one item is in flight at a time; the next is taken while a result waits
// reset clears control and config registers; the tables hold no reset value
// m_tready low holds the result; the next item then waits in its last state and holds off input
module weighted_stripe_mapper_top #(
    parameter int SEGMENTS    = 16,
    parameter int MAX_MEMBERS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // logical_offset, segment_slot, member_slot, new_begin, new_end,
    // new_stripe, new_member_count, new_weight, new_disk, zero pad
    input  logic [wsm_pkg::IN_DATA_W-1:0]       s_tdata,
    // mode
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // disk_id, segment_index, disk_offset, extent_length, zero pad
    output logic [wsm_pkg::OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [2:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data
);

    wsm_pkg::cmd_t  cmd;
    wsm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    wsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsm_datapath #(
        .SEGMENTS    (SEGMENTS),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
